[src/rc4_stream_cipher_unit_defines.svh]
// Assertion macros shared by the cipher unit.
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RC4_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rc4_pkg.sv]
package rc4_pkg;

    localparam int BYTE_W          = 8;
    localparam int ACT_W           = 2;
    localparam int KEY_STORE_DEPTH = 256;
    localparam int KEY_AW          = $clog2(KEY_STORE_DEPTH);
    localparam int S_DEPTH         = 256;
    localparam logic [BYTE_W:0] KEY_LIMIT = (BYTE_W + 1)'(KEY_STORE_DEPTH);
    localparam logic [BYTE_W-1:0] LAST_ENTRY = BYTE_W'(S_DEPTH - 1);

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_KEY   = 2'd0,
        ACT_SCHED = 2'd1,
        ACT_CRYPT = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_READ,
        ST_K_JUPD,
        ST_K_SWAP_N,
        ST_K_SWAP_J,
        ST_C_JUPD,
        ST_C_SWAP_I,
        ST_C_SWAP_J,
        ST_C_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_KEY_WR,
        DP_SCHED_START,
        DP_FILL,
        DP_K_READ,
        DP_K_JUPD,
        DP_K_SWAP_N,
        DP_K_SWAP_J,
        DP_C_START,
        DP_C_JUPD,
        DP_C_SWAP_I,
        DP_C_SWAP_J,
        DP_C_OUT
    } dp_op_t;

    typedef struct packed {
        logic last_n;
        logic out_free;
    } stat_t;

endpackage

[src/rc4_in_if.sv]
interface rc4_in_if;
    logic                           valid;
    logic                           ready;
    logic [rc4_pkg::ACT_W-1:0]      action;
    logic [rc4_pkg::BYTE_W-1:0]     key_index;
    logic [rc4_pkg::BYTE_W-1:0]     key_byte;
    logic [rc4_pkg::BYTE_W-1:0]     key_length;
    logic [rc4_pkg::BYTE_W-1:0]     data_in;

    modport source
    (
        output valid, action, key_index, key_byte, key_length, data_in,
        input  ready
    );

    modport sink
    (
        input  valid, action, key_index, key_byte, key_length, data_in,
        output ready
    );
endinterface

[src/rc4_out_if.sv]
interface rc4_out_if;
    logic                           valid;
    logic                           ready;
    logic [rc4_pkg::BYTE_W-1:0]     data_out;

    modport source
    (
        output valid, data_out,
        input  ready
    );

    modport sink
    (
        input  valid, data_out,
        output ready
    );
endinterface

[src/rc4_ctrl.sv]
module rc4_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rc4_pkg::ACT_W-1:0]   in_action,
    output logic                        in_ready,
    input  rc4_pkg::stat_t              stat,
    output rc4_pkg::dp_op_t             op
);

    rc4_pkg::state_t state_reg;
    rc4_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = rc4_pkg::DP_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (rc4_pkg::act_t'(in_action))
                        rc4_pkg::ACT_KEY:
                        begin
                            op = rc4_pkg::DP_KEY_WR;
                        end
                        rc4_pkg::ACT_SCHED:
                        begin
                            op         = rc4_pkg::DP_SCHED_START;
                            state_next = rc4_pkg::ST_FILL;
                        end
                        rc4_pkg::ACT_CRYPT:
                        begin
                            op         = rc4_pkg::DP_C_START;
                            state_next = rc4_pkg::ST_C_JUPD;
                        end
                        default:
                        begin
                            // unused action: take the word, drop it
                            op = rc4_pkg::DP_IDLE;
                        end
                    endcase
                end
            end
            rc4_pkg::ST_FILL:
            begin
                op = rc4_pkg::DP_FILL;
                if (stat.last_n)
                begin
                    state_next = rc4_pkg::ST_K_READ;
                end
            end
            rc4_pkg::ST_K_READ:
            begin
                op         = rc4_pkg::DP_K_READ;
                state_next = rc4_pkg::ST_K_JUPD;
            end
            rc4_pkg::ST_K_JUPD:
            begin
                op         = rc4_pkg::DP_K_JUPD;
                state_next = rc4_pkg::ST_K_SWAP_N;
            end
            rc4_pkg::ST_K_SWAP_N:
            begin
                op         = rc4_pkg::DP_K_SWAP_N;
                state_next = rc4_pkg::ST_K_SWAP_J;
            end
            rc4_pkg::ST_K_SWAP_J:
            begin
                op         = rc4_pkg::DP_K_SWAP_J;
                state_next = stat.last_n ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_READ;
            end
            rc4_pkg::ST_C_JUPD:
            begin
                op         = rc4_pkg::DP_C_JUPD;
                state_next = rc4_pkg::ST_C_SWAP_I;
            end
            rc4_pkg::ST_C_SWAP_I:
            begin
                op         = rc4_pkg::DP_C_SWAP_I;
                state_next = rc4_pkg::ST_C_SWAP_J;
            end
            rc4_pkg::ST_C_SWAP_J:
            begin
                op         = rc4_pkg::DP_C_SWAP_J;
                state_next = rc4_pkg::ST_C_OUT;
            end
            rc4_pkg::ST_C_OUT:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    op         = rc4_pkg::DP_C_OUT;
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/rc4_dp.sv]
module rc4_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rc4_pkg::dp_op_t             op,
    output rc4_pkg::stat_t              stat,
    input  rc4_pkg::byte_t              key_index,
    input  rc4_pkg::byte_t              key_byte,
    input  rc4_pkg::byte_t              key_length,
    input  rc4_pkg::byte_t              data_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rc4_pkg::byte_t              data_out
);

    rc4_pkg::byte_t s_mem [rc4_pkg::S_DEPTH];
    rc4_pkg::byte_t key_mem [rc4_pkg::KEY_STORE_DEPTH];

    rc4_pkg::byte_t i_reg;
    rc4_pkg::byte_t j_reg;
    rc4_pkg::byte_t n_reg;
    rc4_pkg::byte_t k_reg;
    logic           out_valid_reg;

    rc4_pkg::byte_t s_rd_reg;
    rc4_pkg::byte_t key_rd_reg;
    logic           key_ok_reg;
    rc4_pkg::byte_t a_reg;
    rc4_pkg::byte_t b_reg;
    rc4_pkg::byte_t t_reg;
    rc4_pkg::byte_t len_reg;
    rc4_pkg::byte_t din_reg;
    rc4_pkg::byte_t dout_reg;

    rc4_pkg::byte_t key_val;
    rc4_pkg::byte_t k_inc;
    rc4_pkg::byte_t s_rd_addr;
    logic           s_rd_en;
    rc4_pkg::byte_t s_wr_addr;
    rc4_pkg::byte_t s_wr_data;
    logic           s_wr_en;
    logic           key_wr_en;

    assign key_val = key_ok_reg ? key_rd_reg : '0;
    assign k_inc   = k_reg + 8'd1;

    assign stat.last_n   = (n_reg == rc4_pkg::LAST_ENTRY);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign data_out  = dout_reg;

    assign key_wr_en = (op == rc4_pkg::DP_KEY_WR)
                       && ({1'b0, key_index} < rc4_pkg::KEY_LIMIT);

    // one read and one write on the permutation per cycle
    always_comb
    begin
        s_rd_en   = 1'b0;
        s_rd_addr = n_reg;
        s_wr_en   = 1'b0;
        s_wr_addr = n_reg;
        s_wr_data = s_rd_reg;
        case (op)
            rc4_pkg::DP_FILL:
            begin
                s_wr_en   = 1'b1;
                s_wr_data = n_reg;
            end
            rc4_pkg::DP_K_READ:
            begin
                s_rd_en = 1'b1;
            end
            rc4_pkg::DP_K_JUPD:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = j_reg + s_rd_reg + key_val;
            end
            rc4_pkg::DP_K_SWAP_N:
            begin
                s_wr_en = 1'b1;
            end
            rc4_pkg::DP_K_SWAP_J:
            begin
                s_wr_en   = 1'b1;
                s_wr_addr = j_reg;
                s_wr_data = a_reg;
            end
            rc4_pkg::DP_C_START:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = i_reg + 8'd1;
            end
            rc4_pkg::DP_C_JUPD:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = j_reg + s_rd_reg;
            end
            rc4_pkg::DP_C_SWAP_I:
            begin
                s_wr_en   = 1'b1;
                s_wr_addr = i_reg;
            end
            rc4_pkg::DP_C_SWAP_J:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = a_reg + b_reg;
                s_wr_en   = 1'b1;
                s_wr_addr = j_reg;
                s_wr_data = a_reg;
            end
            default:
            begin
                s_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_wr_en)
        begin
            s_mem[s_wr_addr] <= s_wr_data;
        end
        if (s_rd_en)
        begin
            s_rd_reg <= s_mem[s_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[key_index[rc4_pkg::KEY_AW-1:0]] <= key_byte;
        end
        if (op == rc4_pkg::DP_K_READ)
        begin
            key_rd_reg <= key_mem[k_reg[rc4_pkg::KEY_AW-1:0]];
            key_ok_reg <= ({1'b0, k_reg} < rc4_pkg::KEY_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (op)
                rc4_pkg::DP_SCHED_START:
                begin
                    n_reg <= '0;
                    k_reg <= '0;
                    j_reg <= '0;
                end
                rc4_pkg::DP_FILL:
                begin
                    n_reg <= n_reg + 8'd1;
                end
                rc4_pkg::DP_K_JUPD:
                begin
                    j_reg <= s_rd_addr;
                end
                rc4_pkg::DP_K_SWAP_J:
                begin
                    n_reg <= n_reg + 8'd1;
                    k_reg <= (k_inc == len_reg) ? '0 : k_inc;
                    if (stat.last_n)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                end
                rc4_pkg::DP_C_START:
                begin
                    i_reg <= s_rd_addr;
                end
                rc4_pkg::DP_C_JUPD:
                begin
                    j_reg <= s_rd_addr;
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase

            if (op == rc4_pkg::DP_C_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            rc4_pkg::DP_SCHED_START:
            begin
                len_reg <= key_length;
            end
            rc4_pkg::DP_K_JUPD:
            begin
                a_reg <= s_rd_reg;
            end
            rc4_pkg::DP_C_START:
            begin
                din_reg <= data_in;
            end
            rc4_pkg::DP_C_JUPD:
            begin
                a_reg <= s_rd_reg;
            end
            rc4_pkg::DP_C_SWAP_I:
            begin
                b_reg <= s_rd_reg;
            end
            rc4_pkg::DP_C_SWAP_J:
            begin
                t_reg <= s_rd_addr;
            end
            rc4_pkg::DP_C_OUT:
            begin
                // the read of S[t] raced the write of S[j]: forward it
                dout_reg <= din_reg ^ ((t_reg == j_reg) ? a_reg : s_rd_reg);
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

endmodule

[src/rc4_stream_cipher_unit.sv]
// Channel   Dir  Payload                                             Handshake
// in_ch     in   action, key_index, key_byte, key_length, data_in    valid/ready
// out_ch    out  data_out (one word per crypt word only)             valid/ready
//
// Key byte write: on accept. Crypt word: j update, swap S[i], swap S[j], output load;
// the steps are set by the single read port of the permutation memory.
// Key schedule: 256 identity writes; per entry: read, j update, swap S[n], swap S[j].
// rst_n clears controller, indices and output valid; the memories are not cleared.
// A finished word waits in the output register while the next word is taken;
// a crypt word holds in its last step while that register is still full.
module rc4_stream_cipher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    rc4_in_if.sink      in_ch,
    rc4_out_if.source   out_ch
);

`include "rc4_stream_cipher_unit_defines.svh"

    rc4_pkg::dp_op_t op;
    rc4_pkg::stat_t  stat;

    // Controller: sequences key writes, the schedule and each crypt word.
    rc4_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .op        (op)
    );

    // Datapath: permutation, key store, indices and the output register.
    rc4_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .stat       (stat),
        .key_index  (in_ch.key_index),
        .key_byte   (in_ch.key_byte),
        .key_length (in_ch.key_length),
        .data_in    (in_ch.data_in),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .data_out   (out_ch.data_out)
    );

    // An accepted crypt word must go straight on to the j update.
    `RC4_ASSERT_NEXT(a_crypt_start,
        in_ch.valid && in_ch.ready && in_ch.action == rc4_pkg::ACT_CRYPT,
        op == rc4_pkg::DP_C_JUPD, "crypt word did not advance to j update")

    // Never load the output register over an untaken word.
    `RC4_ASSERT_IMPLY(a_out_no_overwrite,
        op == rc4_pkg::DP_C_OUT, stat.out_free, "output word overwritten")

    // The identity fill ends on the last entry and hands over to the swaps.
    `RC4_ASSERT_NEXT(a_fill_to_swap,
        op == rc4_pkg::DP_FILL && stat.last_n,
        op == rc4_pkg::DP_K_READ, "fill did not hand over to key schedule")

endmodule
